// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk, idle in reset.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, idle in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/cpjd_pkg.sv -----
package cpjd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int NUM_CLASSES = 3;

  // Width of the id fields on the ports.
  localparam int FIELD_W = 16;
  // Stored id width, the smaller of ID_WIDTH and FIELD_W; the low bits of the arriving id are kept.
  localparam int STORE_W = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_CLASSES * QUEUE_DEPTH);

  localparam logic       OP_ARRIVE = 1'b0;
  localparam logic       OP_FINISH = 1'b1;

  localparam logic [1:0] CLS_A    = 2'd0;
  localparam logic [1:0] CLS_B    = 2'd1;
  localparam logic [1:0] CLS_C    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [STORE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] finished_id;
    logic               dispatched;
    logic [1:0]         dispatch_slot;
    logic [FIELD_W-1:0] dispatch_id;
    logic [15:0]        done_count_a;
    logic [15:0]        done_count_b;
    logic [15:0]        done_count_c;
  } result_t;

endpackage

// ----- rtl/core/cpjd_queue_mem.sv -----
module cpjd_queue_mem (
  input  logic                          clk,
  input  cpjd_pkg::mem_req_t            req,
  output logic [cpjd_pkg::STORE_W-1:0]  rd_data
);

  logic [cpjd_pkg::STORE_W-1:0] mem [cpjd_pkg::NUM_CLASSES * cpjd_pkg::QUEUE_DEPTH];

  // Read returns the old contents on a same-address write; the controller forwards.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ----- rtl/core/cpjd_ctrl.sv -----
module cpjd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [1:0]                    job_class,
  input  logic [15:0]                   job_id,
  output cpjd_pkg::mem_req_t            mem_req,
  input  logic [cpjd_pkg::STORE_W-1:0]  rd_data,
  output logic                          res_valid,
  output cpjd_pkg::result_t             res,
  input  logic                          res_take
);

  localparam int NC = cpjd_pkg::NUM_CLASSES;

  logic [cpjd_pkg::PTR_W-1:0]   heads [NC];
  logic [cpjd_pkg::PTR_W-1:0]   tails [NC];
  logic [cpjd_pkg::CNT_W-1:0]   counts [NC];
  logic [NC-1:0]                busy;
  logic [cpjd_pkg::STORE_W-1:0] slot_job [NC];
  logic [15:0]                  done_cnt [NC];

  logic                         pend_valid;
  logic [1:0]                   pend_status;
  logic [cpjd_pkg::FIELD_W-1:0] pend_finished;
  logic                         pend_disp;
  logic [1:0]                   pend_slot;
  logic                         pend_fwd;
  logic [cpjd_pkg::STORE_W-1:0] pend_fwd_id;

  logic                         accept;
  logic [cpjd_pkg::STORE_W-1:0] id_in;
  logic [NC-1:0]                enq, fin, full, ne, busy_post;
  logic [cpjd_pkg::CNT_W-1:0]   cnt_post [NC];
  logic                         disp;
  logic [1:0]                   dslot, dq;
  logic [1:0]                   status_now;
  logic [cpjd_pkg::FIELD_W-1:0] finished_now;
  logic [cpjd_pkg::STORE_W-1:0] did;

  function automatic logic [cpjd_pkg::PTR_W-1:0] next_pos(
    input logic [cpjd_pkg::PTR_W-1:0] p
  );
    return (p == cpjd_pkg::PTR_W'(cpjd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [cpjd_pkg::ADDR_W-1:0] queue_addr(
    input logic [1:0]                 q,
    input logic [cpjd_pkg::PTR_W-1:0] p
  );
    return cpjd_pkg::ADDR_W'(q) * cpjd_pkg::ADDR_W'(cpjd_pkg::QUEUE_DEPTH)
           + cpjd_pkg::ADDR_W'(p);
  endfunction

  assign in_ready = !pend_valid;
  assign accept   = in_valid && in_ready;
  assign id_in    = job_id[cpjd_pkg::STORE_W-1:0];

  // Apply the arrival or the finish, then pick the dispatch on the result.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      full[k]      = (counts[k] == cpjd_pkg::CNT_W'(cpjd_pkg::QUEUE_DEPTH));
      enq[k]       = (job_class == 2'(k)) && (op == cpjd_pkg::OP_ARRIVE) && !full[k];
      fin[k]       = (job_class == 2'(k)) && (op == cpjd_pkg::OP_FINISH) && busy[k];
      cnt_post[k]  = counts[k] + cpjd_pkg::CNT_W'(enq[k]);
      ne[k]        = (cnt_post[k] != '0);
      busy_post[k] = busy[k] && !fin[k];
    end

    status_now   = cpjd_pkg::ST_OK;
    finished_now = '0;
    case (job_class)
      cpjd_pkg::CLS_A, cpjd_pkg::CLS_B, cpjd_pkg::CLS_C: begin
        if (op == cpjd_pkg::OP_ARRIVE) begin
          if (full[job_class]) begin
            status_now = cpjd_pkg::ST_DROP;
          end
        end else if (busy[job_class]) begin
          finished_now = cpjd_pkg::FIELD_W'(slot_job[job_class]);
        end else begin
          status_now = cpjd_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_now = cpjd_pkg::ST_OK;
      end
    endcase

    disp  = 1'b0;
    dslot = cpjd_pkg::CLS_A;
    dq    = cpjd_pkg::CLS_A;
    if (!busy_post[2] && (ne[2] || ne[1] || ne[0])) begin
      disp  = 1'b1;
      dslot = cpjd_pkg::CLS_C;
      dq    = ne[2] ? cpjd_pkg::CLS_C : (ne[1] ? cpjd_pkg::CLS_B : cpjd_pkg::CLS_A);
    end else if (!busy_post[1] && (ne[1] || ne[0])) begin
      disp  = 1'b1;
      dslot = cpjd_pkg::CLS_B;
      dq    = ne[1] ? cpjd_pkg::CLS_B : cpjd_pkg::CLS_A;
    end else if (!busy_post[0] && ne[0]) begin
      disp  = 1'b1;
      dslot = cpjd_pkg::CLS_A;
      dq    = cpjd_pkg::CLS_A;
    end
  end

  // Class code 3 never writes, so its tail lookup is don't-care.
  always_comb begin
    mem_req.we    = accept && (enq != '0);
    mem_req.waddr = queue_addr(job_class, tails[job_class]);
    mem_req.wdata = id_in;
    mem_req.re    = accept && disp;
    mem_req.raddr = queue_addr(dq, heads[dq]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) begin
        heads[k]    <= '0;
        tails[k]    <= '0;
        counts[k]   <= '0;
        done_cnt[k] <= '0;
      end
      busy       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        for (int k = 0; k < NC; k++) begin
          if (enq[k]) begin
            tails[k] <= next_pos(tails[k]);
          end
          if (disp && (dq == 2'(k))) begin
            heads[k]  <= next_pos(heads[k]);
            counts[k] <= cnt_post[k] - 1'b1;
          end else begin
            counts[k] <= cnt_post[k];
          end
          if (fin[k] && (done_cnt[k] != '1)) begin
            done_cnt[k] <= done_cnt[k] + 1'b1;
          end
          busy[k] <= busy_post[k] || (disp && (dslot == 2'(k)));
        end
        pend_valid <= 1'b1;
      end else if (res_take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload of the item in flight; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status   <= status_now;
      pend_finished <= finished_now;
      pend_disp     <= disp;
      pend_slot     <= disp ? dslot : cpjd_pkg::CLS_A;
      // The head is the entry being written when the queue was empty before.
      pend_fwd      <= enq[dq] && (counts[dq] == '0);
      pend_fwd_id   <= id_in;
    end
    if (pend_valid && pend_disp) begin
      slot_job[pend_slot] <= did;
    end
  end

  assign did       = pend_fwd ? pend_fwd_id : rd_data;
  assign res_valid = pend_valid;

  always_comb begin
    res.status        = pend_status;
    res.finished_id   = pend_finished;
    res.dispatched    = pend_disp;
    res.dispatch_slot = pend_slot;
    res.dispatch_id   = pend_disp ? cpjd_pkg::FIELD_W'(did) : '0;
    res.done_count_a  = done_cnt[0];
    res.done_count_b  = done_cnt[1];
    res.done_count_c  = done_cnt[2];
  end

endmodule

// ----- rtl/core/class_partition_job_dispatcher.sv -----
// Class-partitioned job dispatcher. Holds three FIFO queues of job ids (classes
// A, B, C) in one shared synchronous RAM and three execution slots in flops.
// Each input transfer either enqueues a job (op 0) or reports the job in the
// slot of job_class finished (op 1); one result transfer follows for every input
// transfer, carrying the status, the finished id, at most one dispatch (slot C
// takes C, else B, else A; slot B takes B, else A; slot A takes A) and the
// saturating completion counts. On acceptance an item updates the queue
// pointers and issues the RAM write of an arrival and the RAM read of the
// dispatched head; the registered read data is collected after that. An arrival
// into an empty queue that is dispatched at once is forwarded round the RAM. The
// result sits in an output register, so a stalled consumer only holds the next
// item back once that item has collected its read data. A full queue drops
// the arrival with status 1; a finish on an empty slot gives status 2. Class
// code 3 changes nothing but still runs the dispatch. The RAM needs no clearing
// after reset: entries are read only after they were written.
module class_partition_job_dispatcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [1:0]  job_class,
  input  logic [15:0] job_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] finished_id,
  output logic        dispatched,
  output logic [1:0]  dispatch_slot,
  output logic [15:0] dispatch_id,
  output logic [15:0] done_count_a,
  output logic [15:0] done_count_b,
  output logic [15:0] done_count_c
);

  cpjd_pkg::mem_req_t           mem_req;
  logic [cpjd_pkg::STORE_W-1:0] rd_data;
  logic                         res_valid;
  cpjd_pkg::result_t            res;
  logic                         res_take;

  cpjd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .job_class (job_class),
    .job_id    (job_id),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  cpjd_queue_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Move the finished item into the output register whenever it is free or
  // being emptied this cycle.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload until its transfer completes.
  always_ff @(posedge clk) begin
    if (res_take) begin
      status        <= res.status;
      finished_id   <= res.finished_id;
      dispatched    <= res.dispatched;
      dispatch_slot <= res.dispatch_slot;
      dispatch_id   <= res.dispatch_id;
      done_count_a  <= res.done_count_a;
      done_count_b  <= res.done_count_b;
      done_count_c  <= res.done_count_c;
    end
  end

endmodule

// ----- rtl/core/cpjd_checker.sv -----
`include "assert_macros.svh"

module cpjd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        op,
  input logic [1:0]  job_class,
  input logic [15:0] job_id,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] finished_id,
  input logic        dispatched,
  input logic [1:0]  dispatch_slot,
  input logic [15:0] dispatch_id,
  input logic [15:0] done_count_a,
  input logic [15:0] done_count_b,
  input logic [15:0] done_count_c
);

  `CHK_SAME(a_no_disp_zero, out_valid && !dispatched,
            (dispatch_slot == 2'd0) && (dispatch_id == 16'd0),
            "idle dispatch fields not zero")
  `CHK_SAME(a_empty_finish, out_valid && (status == cpjd_pkg::ST_EMPTY),
            finished_id == 16'd0, "empty-slot finish reports an id")
  `CHK_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
            "second item taken while one is in flight")
  `CHK_NEXT(a_in_hold, in_valid && !in_ready,
            in_valid && $stable(op) && $stable(job_class) && $stable(job_id),
            "waiting input dropped or changed")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready,
            out_valid && $stable(status) && $stable(finished_id) && $stable(dispatched)
            && $stable(dispatch_slot) && $stable(dispatch_id) && $stable(done_count_a)
            && $stable(done_count_b) && $stable(done_count_c),
            "stalled result changed")

endmodule

bind class_partition_job_dispatcher cpjd_checker u_cpjd_checker (.*);
